[hdl/pfe_pkg.sv]
package pfe_pkg;

   // datapath word and default stack size
   localparam int WORD_WIDTH      = 32;
   localparam int CNT_WIDTH       = $clog2(WORD_WIDTH);
   localparam int STACK_DEPTH_DEF = 16;

   // token kinds
   localparam logic [2:0] KIND_OPERAND = 3'd0;
   localparam logic [2:0] KIND_ADD     = 3'd1;
   localparam logic [2:0] KIND_SUB     = 3'd2;
   localparam logic [2:0] KIND_MUL     = 3'd3;
   localparam logic [2:0] KIND_DIV     = 3'd4;
   localparam logic [2:0] KIND_END     = 3'd5;

   // response status codes
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_FEW      = 3'd1;
   localparam logic [2:0] STATUS_LEFT     = 3'd2;
   localparam logic [2:0] STATUS_OVERFLOW = 3'd3;
   localparam logic [2:0] STATUS_DIVZERO  = 3'd4;

   // serial unit operations
   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_MUL = 2'd2,
      ALU_DIV = 2'd3
   } alu_op_type;

   // command from the sequencer to the serial unit
   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_DECODE = 4'b0100,
      ST_EXEC   = 4'b1000
   } state_type;

endpackage

[hdl/pfe_stack.sv]
module pfe_stack #(
   parameter int  DEPTH = pfe_pkg::STACK_DEPTH_DEF,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [AW-1:0]                   wr_addr,
   input  logic [pfe_pkg::WORD_WIDTH-1:0]  wr_data,
   input  logic [AW-1:0]                   top_addr,
   input  logic [AW-1:0]                   next_addr,
   output logic [pfe_pkg::WORD_WIDTH-1:0]  top_data,
   output logic [pfe_pkg::WORD_WIDTH-1:0]  next_data
);

   logic [pfe_pkg::WORD_WIDTH-1:0] stack_ff [DEPTH];
   logic [pfe_pkg::WORD_WIDTH-1:0] top_ff;
   logic [pfe_pkg::WORD_WIDTH-1:0] next_ff;

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_ff[wr_addr] <= wr_data;
      end
      top_ff  <= stack_ff[top_addr];
      next_ff <= stack_ff[next_addr];
   end

   assign top_data  = top_ff;
   assign next_data = next_ff;

endmodule

[hdl/pfe_alu.sv]
module pfe_alu (
   input  logic                            clock,
   input  logic                            reset,
   input  pfe_pkg::alu_req_type            alu_req,
   input  logic [pfe_pkg::WORD_WIDTH-1:0]  a,
   input  logic [pfe_pkg::WORD_WIDTH-1:0]  b,
   output logic                            done,
   output logic [pfe_pkg::WORD_WIDTH-1:0]  result
);

   localparam int W = pfe_pkg::WORD_WIDTH;
   localparam logic [pfe_pkg::CNT_WIDTH-1:0] LAST = pfe_pkg::CNT_WIDTH'(W - 1);

   logic                          busy_ff, busy_in;
   logic                          fix_ff, fix_in;
   logic                          done_ff, done_in;
   pfe_pkg::alu_op_type           op_ff, op_in;
   logic [pfe_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [W-1:0]                  x_ff, x_in;
   logic [W-1:0]                  y_ff, y_in;
   logic [W-1:0]                  acc_ff, acc_in;
   logic [W-1:0]                  res_ff, res_in;
   logic                          carry_ff, carry_in;
   logic                          neg_ff, neg_in;
   logic                          sub_bit;
   logic                          sum_bit;
   logic [W-1:0]                  rem_shift;
   logic [W:0]                    diff;
   logic                          take;

   // serial add/subtract bit, divide trial subtract
   assign sub_bit   = x_ff[0] ^ (op_ff == pfe_pkg::ALU_SUB);
   assign sum_bit   = y_ff[0] ^ sub_bit ^ carry_ff;
   assign rem_shift = {acc_ff[W-2:0], y_ff[W-1]};
   assign diff      = {1'b0, rem_shift} - {1'b0, x_ff};
   assign take      = ~diff[W];

   // one bit of the operation per cycle
   always_comb begin
      busy_in  = busy_ff;
      fix_in   = fix_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      carry_in = carry_ff;
      neg_in   = neg_ff;
      if (alu_req.start) begin
         op_in    = alu_req.op;
         busy_in  = 1'b1;
         fix_in   = 1'b0;
         cnt_in   = '0;
         acc_in   = '0;
         carry_in = (alu_req.op == pfe_pkg::ALU_SUB);
         neg_in   = a[W-1] ^ b[W-1];
         if (alu_req.op == pfe_pkg::ALU_DIV) begin
            x_in = a[W-1] ? (~a + W'(1)) : a;
            y_in = b[W-1] ? (~b + W'(1)) : b;
         end else begin
            x_in = a;
            y_in = b;
         end
      end else if (busy_ff) begin
         unique case (op_ff)
            pfe_pkg::ALU_ADD, pfe_pkg::ALU_SUB: begin
               carry_in = (y_ff[0] & sub_bit) | (y_ff[0] & carry_ff) | (sub_bit & carry_ff);
               acc_in   = {sum_bit, acc_ff[W-1:1]};
               x_in     = {1'b0, x_ff[W-1:1]};
               y_in     = {1'b0, y_ff[W-1:1]};
            end
            pfe_pkg::ALU_MUL: begin
               if (x_ff[0]) begin
                  acc_in = acc_ff + y_ff;
               end
               x_in = {1'b0, x_ff[W-1:1]};
               y_in = {y_ff[W-2:0], 1'b0};
            end
            pfe_pkg::ALU_DIV: begin
               acc_in = take ? diff[W-1:0] : rem_shift;
               y_in   = {y_ff[W-2:0], take};
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         cnt_in = cnt_ff + pfe_pkg::CNT_WIDTH'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            if (op_ff == pfe_pkg::ALU_DIV) begin
               fix_in = 1'b1;
            end else begin
               done_in = 1'b1;
               res_in  = acc_in;
            end
         end
      end else if (fix_ff) begin
         // quotient sign
         fix_in  = 1'b0;
         done_in = 1'b1;
         res_in  = neg_ff ? (~y_ff + W'(1)) : y_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      cnt_ff   <= cnt_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      acc_ff   <= acc_in;
      res_ff   <= res_in;
      carry_ff <= carry_in;
      neg_ff   <= neg_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

[hdl/postfix_expression_evaluator_top.sv]
// Postfix (reverse Polish) evaluator, one token per request. An operand pushes its value onto
// a stack of STACK_DEPTH 32-bit words; add, subtract, multiply and divide pop the top value a
// and the next value b and push a+b, b-a, a*b or b/a (32-bit wrap, division truncates toward
// zero). The first error (too few operands, stack overflow, divide by zero) is held until the
// end token, which returns a status, with the value if exactly one remains and no error was
// held (else zero), and clears the stack. Tokens are handled one at a time: each accepted
// token passes through a stack read state and a decode state before the next can be accepted;
// an arithmetic token that reaches the serial unit also waits in an execute state for the
// bit-serial unit, which does one bit of the add, subtract, multiply or restoring divide per
// cycle, with a further sign step for divide. A finished response sits in an output register,
// so further tokens are taken while it waits; only another end token is held back until the
// earlier response is taken.
module postfix_expression_evaluator_top #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic [30:0]        req_operand_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic [2:0]         rsp_status
);

   localparam int W  = pfe_pkg::WORD_WIDTH;
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

   pfe_pkg::state_type   state_ff, state_in;
   logic [2:0]           kind_ff, kind_in;
   logic [30:0]          value_ff, value_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [2:0]           err_ff, err_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]         rsp_value_ff, rsp_value_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic                 accept;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [W-1:0]         wr_data;
   logic [AW-1:0]        top_addr;
   logic [AW-1:0]        next_addr;
   logic [W-1:0]         top_data;
   logic [W-1:0]         next_data;
   pfe_pkg::alu_req_type alu_req;
   logic                 alu_done;
   logic [W-1:0]         alu_result;

   // request handshake
   assign req_stall = (state_ff != pfe_pkg::ST_IDLE)
                      || (rsp_valid_ff && (req_kind == pfe_pkg::KIND_END));
   assign accept    = req_valid && !req_stall;

   // stack top and next entry
   assign top_addr  = AW'(count_ff - CW'(1));
   assign next_addr = AW'(count_ff - CW'(2));

   pfe_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .top_addr  (top_addr),
      .next_addr (next_addr),
      .top_data  (top_data),
      .next_data (next_data)
   );

   pfe_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .a       (top_data),
      .b       (next_data),
      .done    (alu_done),
      .result  (alu_result)
   );

   // token sequencer
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(count_ff);
      wr_data       = {1'b0, value_ff};
      alu_req.start = 1'b0;
      alu_req.op    = pfe_pkg::ALU_ADD;
      unique case (kind_ff)
         pfe_pkg::KIND_SUB: alu_req.op = pfe_pkg::ALU_SUB;
         pfe_pkg::KIND_MUL: alu_req.op = pfe_pkg::ALU_MUL;
         pfe_pkg::KIND_DIV: alu_req.op = pfe_pkg::ALU_DIV;
         default:           alu_req.op = pfe_pkg::ALU_ADD;
      endcase
      unique case (state_ff)
         pfe_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in  = req_kind;
               value_in = req_operand_value;
               state_in = pfe_pkg::ST_READ;
            end
         end
         pfe_pkg::ST_READ: begin
            state_in = pfe_pkg::ST_DECODE;
         end
         pfe_pkg::ST_DECODE: begin
            state_in = pfe_pkg::ST_IDLE;
            priority if (kind_ff == pfe_pkg::KIND_END) begin
               // final response, then clear
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               if (err_ff != pfe_pkg::STATUS_OK) begin
                  rsp_status_in = err_ff;
               end else if (count_ff == CW'(1)) begin
                  rsp_status_in = pfe_pkg::STATUS_OK;
                  rsp_value_in  = top_data;
               end else begin
                  rsp_status_in = pfe_pkg::STATUS_LEFT;
               end
               count_in = '0;
               err_in   = pfe_pkg::STATUS_OK;
            end else if ((kind_ff > pfe_pkg::KIND_END) || (err_ff != pfe_pkg::STATUS_OK)) begin
               // ignored token
               state_in = pfe_pkg::ST_IDLE;
            end else if (kind_ff == pfe_pkg::KIND_OPERAND) begin
               if (count_ff >= DEPTH_C) begin
                  err_in = pfe_pkg::STATUS_OVERFLOW;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end else if (count_ff < CW'(2)) begin
               err_in = pfe_pkg::STATUS_FEW;
            end else if ((kind_ff == pfe_pkg::KIND_DIV) && (top_data == '0)) begin
               err_in = pfe_pkg::STATUS_DIVZERO;
            end else begin
               alu_req.start = 1'b1;
               state_in      = pfe_pkg::ST_EXEC;
            end
         end
         pfe_pkg::ST_EXEC: begin
            // result replaces the next entry, stack shrinks by one
            if (alu_done) begin
               wr_en    = 1'b1;
               wr_addr  = next_addr;
               wr_data  = alu_result;
               count_in = count_ff - CW'(1);
               state_in = pfe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfe_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfe_pkg::ST_IDLE;
         count_ff     <= '0;
         err_ff       <= pfe_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = $signed(rsp_value_ff);
   assign rsp_status       = rsp_status_ff;

endmodule

[hdl/pfe_checker.sv]
module pfe_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [2:0]         req_kind,
   input logic [30:0]        req_operand_value,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_result_value,
   input logic [2:0]         rsp_status
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value) && $stable(rsp_status))
      else $error("stalled response changed");

   // failed expression reports zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != pfe_pkg::STATUS_OK) |-> rsp_result_value == 32'sd0)
      else $error("nonzero value with error status");

   // accepted end request gives a response after the stack read and decode states
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == pfe_pkg::KIND_END) |-> ##3 rsp_valid)
      else $error("end request gave no response");

   // a new response only follows an end request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && (req_kind == pfe_pkg::KIND_END), 3))
      else $error("response without end request");

endmodule

bind postfix_expression_evaluator_top pfe_checker u_checker (.*);

[dv/postfix_expression_evaluator_top_tb.sv]
`timescale 1ns / 100ps

module postfix_expression_evaluator_top_tb;

   localparam int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF;
   localparam int TOKEN_TARGET = 750;
   localparam int QUIET_LIMIT = 5000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_TAIL_CYCLES = 40;
   localparam logic [30:0] OPERAND_MAX = 31'h7FFF_FFFF;

   // kinds outside the token set, ignored by the block
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   typedef struct {
      logic [2:0]  kind;
      logic [30:0] value;
      bit          drain_first;
   } token_type;

   typedef struct {
      logic signed [31:0] value;
      logic [2:0]         status;
   } eval_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_kind = pfe_pkg::KIND_END;
   logic [30:0]        req_operand_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_result_value;
   logic [2:0]         rsp_status;

   token_type       token_feed[$];
   eval_result_type pending_results[$];

   // shadow evaluator state
   logic [31:0] shadow_stack [STACK_DEPTH];
   int          shadow_depth = 0;
   logic [2:0]  shadow_error = pfe_pkg::STATUS_OK;

   int  tokens_taken = 0;
   int  arith_taken = 0;
   int  results_checked = 0;
   int  error_results = 0;
   int  fail_count = 0;
   int  quiet_cycles = 0;
   int  hold_left = 0;
   bit  long_hold_done = 0;
   int  stim_count = 0;
   bit  drain_next = 0;

   postfix_expression_evaluator_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // idle percentage per side: sender-light, then receiver-light, then none
   function automatic int idle_percent(input bit sender_side);
      if (tokens_taken < 260) return sender_side ? 27 : 86;
      if (tokens_taken < 520) return sender_side ? 86 : 27;
      return 0;
   endfunction

   // apply one accepted token to the shadow stack, queue the response on end
   function automatic void evaluate_token(input logic [2:0] kind, input logic [30:0] value);
      logic [31:0]     a;
      logic [31:0]     b;
      logic [31:0]     c;
      eval_result_type r;
      if (kind == pfe_pkg::KIND_END) begin
         r.status = shadow_error;
         r.value  = '0;
         if (shadow_error == pfe_pkg::STATUS_OK) begin
            if (shadow_depth == 1) r.value = shadow_stack[0];
            else r.status = pfe_pkg::STATUS_LEFT;
         end
         pending_results.insert(pending_results.size(), r);
         shadow_depth = 0;
         shadow_error = pfe_pkg::STATUS_OK;
         return;
      end
      if (kind > pfe_pkg::KIND_END || shadow_error != pfe_pkg::STATUS_OK) return;
      if (kind == pfe_pkg::KIND_OPERAND) begin
         if (shadow_depth >= STACK_DEPTH) begin
            shadow_error = pfe_pkg::STATUS_OVERFLOW;
            return;
         end
         shadow_stack[shadow_depth] = {1'b0, value};
         shadow_depth++;
         return;
      end
      arith_taken++;
      if (shadow_depth < 2) begin
         shadow_error = pfe_pkg::STATUS_FEW;
         return;
      end
      a = shadow_stack[shadow_depth - 1];
      b = shadow_stack[shadow_depth - 2];
      case (kind)
         pfe_pkg::KIND_ADD: c = a + b;
         pfe_pkg::KIND_SUB: c = b - a;
         pfe_pkg::KIND_MUL: c = a * b;
         default: begin
            if (a == '0) begin
               shadow_error = pfe_pkg::STATUS_DIVZERO;
               return;
            end
            // most negative over minus one wraps back to itself
            if (b == 32'h8000_0000 && a == 32'hFFFF_FFFF) c = 32'h8000_0000;
            else c = 32'($signed(b) / $signed(a));
         end
      endcase
      shadow_depth--;
      shadow_stack[shadow_depth - 1] = c;
   endfunction

   // stimulus construction
   function automatic void add_token(input logic [2:0] kind, input logic [30:0] value);
      token_type t;
      t.kind        = kind;
      t.value       = value;
      t.drain_first = drain_next;
      drain_next    = 0;
      token_feed.insert(token_feed.size(), t);
      if (kind <= pfe_pkg::KIND_END) stim_count++;
   endfunction

   function automatic logic [30:0] pick_operand();
      case ($urandom_range(9))
         0, 1: return '0;
         2: return 31'd1;
         3: return OPERAND_MAX;
         4, 5: return 31'($urandom_range(20, 1));
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic logic [2:0] pick_operator();
      return 3'($urandom_range(pfe_pkg::KIND_DIV, pfe_pkg::KIND_ADD));
   endfunction

   // well-formed expression over n operands, operators interleaved at random
   function automatic void gen_expression(input int n);
      int pushed;
      int live;
      pushed = 0;
      live   = 0;
      while (pushed < n || live > 1) begin
         if (live >= 2 && (pushed == n || $urandom_range(1) == 1)) begin
            add_token(pick_operator(), 31'($urandom));
            live--;
         end else begin
            add_token(pfe_pkg::KIND_OPERAND, pick_operand());
            pushed++;
            live++;
         end
      end
      add_token(pfe_pkg::KIND_END, 31'($urandom));
   endfunction

   // push STACK_DEPTH-2 to STACK_DEPTH+1 operands, then usually fold the stack down
   function automatic void gen_deep();
      int n;
      n = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH - 2);
      repeat (n) add_token(pfe_pkg::KIND_OPERAND, pick_operand());
      if ($urandom_range(3) != 0) repeat (n - 1) add_token(pick_operator(), 31'($urandom));
      add_token(pfe_pkg::KIND_END, 31'($urandom));
   endfunction

   // arbitrary tokens, unused kinds included, usually closed by an end
   function automatic void gen_noise();
      repeat ($urandom_range(8, 1)) add_token(3'($urandom), 31'($urandom));
      if ($urandom_range(4) != 0) add_token(pfe_pkg::KIND_END, 31'($urandom));
   endfunction

   // request driver: holds a token until taken, predicts on acceptance
   always @(posedge clock) begin
      token_type nxt;
      logic      offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            evaluate_token(req_kind, req_operand_value);
            tokens_taken++;
         end
         if (!req_valid || !req_stall) begin
            offer = 1'b0;
            if (token_feed.size() > 0 && $urandom_range(99) >= idle_percent(1'b1)) begin
               if (!token_feed[0].drain_first || pending_results.size() == 0) offer = 1'b1;
            end
            if (offer) begin
               nxt = token_feed.pop_front();
               req_kind          <= nxt.kind;
               req_operand_value <= nxt.value;
            end else begin
               req_kind          <= 3'($urandom);
               req_operand_value <= 31'($urandom);
            end
            req_valid <= offer;
         end
      end
   end

   // response stall, with one long hold-off early in the run
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!long_hold_done && tokens_taken >= 60) begin
            hold_left      = LONG_HOLD_CYCLES;
            long_hold_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < idle_percent(1'b0));
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      eval_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response: result_value %0d status %0d",
                   rsp_result_value, rsp_status);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (want.status != pfe_pkg::STATUS_OK) error_results++;
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_result_value !== want.value) begin
               $error("result_value: expected %0d, got %0d", want.value, rsp_result_value);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      int pick;

      // directed: wraps, truncation, quotient overflow, errors, unused kinds
      add_token(pfe_pkg::KIND_OPERAND, OPERAND_MAX);
      add_token(pfe_pkg::KIND_OPERAND, OPERAND_MAX);
      add_token(pfe_pkg::KIND_ADD, '0);
      add_token(pfe_pkg::KIND_END, '0);
      add_token(pfe_pkg::KIND_OPERAND, '0);
      add_token(pfe_pkg::KIND_OPERAND, 31'd7);
      add_token(pfe_pkg::KIND_SUB, OPERAND_MAX);
      add_token(pfe_pkg::KIND_OPERAND, 31'd2);
      add_token(pfe_pkg::KIND_DIV, '0);
      add_token(pfe_pkg::KIND_END, OPERAND_MAX);
      add_token(pfe_pkg::KIND_OPERAND, 31'h4000_0000);
      add_token(pfe_pkg::KIND_OPERAND, 31'd2);
      add_token(pfe_pkg::KIND_MUL, '0);
      add_token(pfe_pkg::KIND_OPERAND, '0);
      add_token(pfe_pkg::KIND_OPERAND, 31'd1);
      add_token(pfe_pkg::KIND_SUB, '0);
      add_token(pfe_pkg::KIND_DIV, '0);
      add_token(pfe_pkg::KIND_END, '0);
      add_token(pfe_pkg::KIND_OPERAND, 31'd1);
      add_token(pfe_pkg::KIND_OPERAND, '0);
      add_token(pfe_pkg::KIND_DIV, '0);
      add_token(KIND_SPARE_LO, OPERAND_MAX);
      add_token(pfe_pkg::KIND_END, '0);
      add_token(pfe_pkg::KIND_SUB, '0);
      add_token(KIND_SPARE_HI, '0);
      add_token(pfe_pkg::KIND_END, '0);
      add_token(pfe_pkg::KIND_END, '0);

      // random: mostly well-formed expressions, some deep stacks and noise
      drain_next = 1;
      while (stim_count < TOKEN_TARGET) begin
         if (stim_count % 120 < 8) drain_next = 1;
         pick = $urandom_range(99);
         if (pick < 65) gen_expression($urandom_range(9) == 0 ?
                                       $urandom_range(STACK_DEPTH, 1) :
                                       $urandom_range(6, 1));
         else if (pick < 80) gen_deep();
         else gen_noise();
      end
      add_token(pfe_pkg::KIND_END, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (token_feed.size() != 0 || req_valid || pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d tokens (%0d arithmetic), %0d responses, %0d with error status",
               tokens_taken, arith_taken, results_checked, error_results);
      $display("under sender-heavy, receiver-heavy and no-idle phases with a long response hold");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[files.f]
hdl/pfe_pkg.sv
hdl/pfe_stack.sv
hdl/pfe_alu.sv
hdl/postfix_expression_evaluator_top.sv
hdl/pfe_checker.sv
dv/postfix_expression_evaluator_top_tb.sv
